>>> design/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the encoder's modules.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, ignored while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> design/dzve_pkg.sv
// -----------------------------------------------------------------------------
// dzve_pkg
// Widths, constants and shared types of the delta/zigzag varint encoder.
// -----------------------------------------------------------------------------
package dzve_pkg;

   localparam int SampleW = 32;
   localparam int ByteW   = 8;
   localparam int GroupW  = 7;

   localparam logic [ByteW-1:0] ContFlag    = 8'h80;
   localparam logic [ByteW-1:0] PayloadMask = 8'h7F;

   // The queue depth must be a power of two so the pointers wrap by themselves.
   localparam int QueueDepth = 2;
   localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCountW    = $clog2(QueueDepth + 1);

   // One zigzag-mapped difference on its way from the front to the back.
   typedef struct packed {
      logic               valid;
      logic [SampleW-1:0] value;
   } dzve_entry_type;

endpackage

>>> design/dzve_if.sv
// -----------------------------------------------------------------------------
// dzve_req_if / dzve_rsp_if
// Valid/ready channels for samples in and varint bytes out.
// -----------------------------------------------------------------------------
interface dzve_req_if;
   import dzve_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SampleW-1:0] sample;
   logic                      block_start;

   modport source (output valid, output sample, output block_start, input ready);
   modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface dzve_rsp_if;
   import dzve_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] code_byte;
   logic             last_byte;

   modport source (output valid, output code_byte, output last_byte, input ready);
   modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

>>> design/dzve_front.sv
// -----------------------------------------------------------------------------
// dzve_front
// Takes samples, forms the wrapped difference and zigzag-maps it.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dzve_front (
   input  logic                    clock,
   input  logic                    reset,
   dzve_req_if.sink                req_if,
   input  logic                    q_full,
   output dzve_pkg::dzve_entry_type push
);
   import dzve_pkg::*;

   logic [SampleW-1:0] prev_ff;
   logic [SampleW-1:0] prev_in;
   logic [SampleW-1:0] base;
   logic [SampleW-1:0] diff;
   logic               accept;

   always_comb begin
      // No sample is taken while reset is high, since it would be dropped.
      accept       = req_if.valid && !q_full && !reset;
      req_if.ready = !q_full && !reset;
      base         = req_if.block_start ? '0 : prev_ff;
      diff         = SampleW'(req_if.sample) - base;
      // Zigzag: shift left and flip all bits when the difference is negative.
      push.valid   = accept;
      push.value   = {diff[SampleW-2:0], 1'b0} ^ {SampleW{diff[SampleW-1]}};
      prev_in      = accept ? SampleW'(req_if.sample) : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   `ASSERT_RST(a_prev_tracks, clock, reset,
      (req_if.valid && req_if.ready) |=> (prev_ff == $past(SampleW'(req_if.sample))))

endmodule

>>> design/dzve_queue.sv
// -----------------------------------------------------------------------------
// dzve_queue
// Short first-in first-out queue between the front and the back.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dzve_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  dzve_pkg::dzve_entry_type push,
   output logic                     full,
   input  logic                     pop,
   output dzve_pkg::dzve_entry_type head
);
   import dzve_pkg::*;

   logic [SampleW-1:0] slot_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff;
   logic [QPtrW-1:0]   wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff;
   logic [QPtrW-1:0]   rd_ptr_in;
   logic [QCountW-1:0] count_ff;
   logic [QCountW-1:0] count_in;

   always_comb begin
      full       = (count_ff == QCountW'(QueueDepth));
      head.valid = (count_ff != '0);
      head.value = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + QCountW'(push.valid) - QCountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.value;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= QCountW'(QueueDepth)))
   `ASSERT_RST(a_pop_nonempty, clock, reset, pop |-> (count_ff != '0))

endmodule

>>> design/dzve_back.sv
// -----------------------------------------------------------------------------
// dzve_back
// Splits each queued value into LEB128 bytes, one byte per cycle unless stalled.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dzve_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dzve_pkg::dzve_entry_type head,
   output logic                     pop,
   dzve_rsp_if.source               rsp_if
);
   import dzve_pkg::*;

   logic               busy_ff, busy_in;
   logic [SampleW-1:0] rest_ff, rest_in;
   logic               out_valid_ff, out_valid_in;
   logic [ByteW-1:0]   byte_ff, byte_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               have;
   logic [SampleW-1:0] src;
   logic [SampleW-1:0] rest;
   logic               last;

   always_comb begin
      out_free     = !out_valid_ff || rsp_if.ready;
      // A value in progress goes first; otherwise the queue head is taken directly.
      src          = busy_ff ? rest_ff : head.value;
      have         = busy_ff || head.valid;
      rest         = src >> GroupW;
      last         = (rest == '0);
      pop          = out_free && !busy_ff && head.valid;

      busy_in      = busy_ff;
      rest_in      = rest_ff;
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (out_free) begin
         out_valid_in = have;
         if (have) begin
            byte_in = (src[ByteW-1:0] & PayloadMask) | (last ? '0 : ContFlag);
            last_in = last;
            rest_in = rest;
            busy_in = !last;
         end
      end

      rsp_if.valid     = out_valid_ff;
      rsp_if.code_byte = byte_ff;
      rsp_if.last_byte = last_ff;
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `ASSERT_RST(a_busy_has_word, clock, reset, busy_ff |-> out_valid_ff)
   `ASSERT_RST(a_cont_flag, clock, reset,
      out_valid_ff |-> (byte_ff[ByteW-1] == !last_ff))

endmodule

>>> design/delta_zigzag_varint_encoder.sv
// -----------------------------------------------------------------------------
// delta_zigzag_varint_encoder
// Delta, zigzag and LEB128 varint coding of signed 32-bit samples.
// -----------------------------------------------------------------------------
//   channel  direction  word                      handshake
//   req_if   in         sample, block_start       valid/ready
//   rsp_if   out        code_byte, last_byte      valid/ready
//
// A sample yields 1 to 5 words on rsp_if; the byte splitter in the back
// emits one word per cycle while rsp_if is ready.
// A sample's first word passes the queue slot and then the back's output
// register before it is valid on rsp_if.
// The two-entry queue lets the front take samples while the back is stalled.
// Reset is synchronous; the previous sample clears to zero.
// -----------------------------------------------------------------------------
module delta_zigzag_varint_encoder (
   input  logic       clock,
   input  logic       reset,
   dzve_req_if.sink   req_if,
   dzve_rsp_if.source rsp_if
);
   import dzve_pkg::*;

   dzve_entry_type push;
   dzve_entry_type head;
   logic           q_full;
   logic           pop;

   dzve_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .push   (push)
   );

   dzve_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   dzve_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

>>> tb/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delta/zigzag varint encoder. A directed table
// covers the corners first (reset state, extremes, wraparound, zero and most
// negative difference), then random samples follow. Both sides idle at random.
// Every code word is compared with typed row bytes or a local encoder model.
// -----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dzve_pkg::*;

   localparam int MaxCodeBytes = 5;
   localparam int NumRandom    = 110;
   localparam int SqueezeAt    = 40;
   localparam int SqueezeLen   = 100;
   localparam int DrainLimit   = 20000;

   typedef struct packed {
      logic [ByteW-1:0] code;
      logic             is_last;
   } code_word_type;

   // A row with n_typed set carries its code bytes, first byte in the low bits.
   typedef struct packed {
      logic [SampleW-1:0]            smp;
      logic                          start;
      logic [2:0]                    n_typed;
      logic [MaxCodeBytes*ByteW-1:0] bytes;
   } stim_row_type;

   localparam int NumDirected = 20;

   stim_row_type directed_rows [NumDirected] = '{
      '{32'h0000_0000, 1'b0, 3'd1, 40'h00},           // zero right after reset
      '{32'h0000_0001, 1'b0, 3'd1, 40'h02},
      '{32'hFFFF_FFFF, 1'b1, 3'd1, 40'h01},
      '{32'hFFFF_FFFF, 1'b0, 3'd1, 40'h00},
      '{32'h0000_003F, 1'b1, 3'd0, 40'h00},
      '{32'h0000_0040, 1'b1, 3'd0, 40'h00},
      '{32'hFFFF_FFC0, 1'b1, 3'd0, 40'h00},
      '{32'h7FFF_FFFF, 1'b1, 3'd5, 40'h0F_FF_FF_FF_FE},
      '{32'h8000_0000, 1'b1, 3'd5, 40'h0F_FF_FF_FF_FF},
      '{32'h7FFF_FFFF, 1'b0, 3'd0, 40'h00},           // difference wraps
      '{32'h8000_0000, 1'b0, 3'd0, 40'h00},
      '{32'h0000_0000, 1'b1, 3'd0, 40'h00},
      '{32'h8000_0000, 1'b0, 3'd5, 40'h0F_FF_FF_FF_FF},
      '{32'h8000_0000, 1'b0, 3'd1, 40'h00},
      '{32'h0000_2000, 1'b1, 3'd0, 40'h00},
      '{32'hFFFF_E000, 1'b1, 3'd0, 40'h00},
      '{32'h0800_0000, 1'b1, 3'd0, 40'h00},
      '{32'h07FF_FFFF, 1'b1, 3'd0, 40'h00},
      '{32'h5555_5555, 1'b0, 3'd0, 40'h00},
      '{32'hAAAA_AAAA, 1'b0, 3'd0, 40'h00}
   };

   logic clock;
   logic reset;

   dzve_req_if req_if ();
   dzve_rsp_if rsp_if ();

   delta_zigzag_varint_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   code_word_type      pending_words [$];
   logic [SampleW-1:0] last_sample;
   logic [SampleW-1:0] last_offered;
   int                 errors;
   int                 words_checked;
   int                 samples_sent;
   int                 starts_sent;
   int                 len_count [1:MaxCodeBytes];
   int                 send_calm;
   int                 pressure_left;
   bit                 squeeze_request;

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 50) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // Delta against the previous sample, zigzag, then 7-bit groups low first.
   function automatic int encode_sample(input logic [SampleW-1:0] smp, input logic start,
                                        output code_word_type [MaxCodeBytes-1:0] words);
      logic [SampleW-1:0] diff;
      logic [SampleW-1:0] zz;
      int                 n;
      diff = smp - (start ? '0 : last_sample);
      zz = {diff[SampleW-2:0], 1'b0} ^ {SampleW{diff[SampleW-1]}};
      last_sample = smp;
      words = '0;
      n = 0;
      do begin
         words[n].is_last = ((zz >> GroupW) == '0) || (n == MaxCodeBytes - 1);
         words[n].code = (ByteW'(zz[GroupW-1:0]) & PayloadMask)
                         | (words[n].is_last ? 8'h00 : ContFlag);
         zz = zz >> GroupW;
         n++;
      end while (!words[n-1].is_last);
      return n;
   endfunction

   function automatic int pick_send_gap();
      int r;
      if (pressure_left > 0 || squeeze_request) return 0;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 93) begin
         send_calm = $urandom_range(8, 20);
         return 0;
      end
      return $urandom_range(10, 30);
   endfunction

   // Offers one sample, waits for it to be taken, then queues its code words.
   task automatic send_sample(input logic [SampleW-1:0] smp, input logic start,
                              input logic [2:0] n_typed,
                              input logic [MaxCodeBytes*ByteW-1:0] typed);
      code_word_type [MaxCodeBytes-1:0] words;
      code_word_type                    w;
      int                               gap;
      int                               n;
      gap = pick_send_gap();
      if (gap > 0) begin
         req_if.valid       <= 1'b0;
         req_if.sample      <= $urandom;
         req_if.block_start <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.sample      <= smp;
      req_if.block_start <= start;
      do @(posedge clock); while (!req_if.ready);
      n = encode_sample(smp, start, words);
      len_count[n]++;
      samples_sent++;
      starts_sent += start;
      last_offered = smp;
      if (n_typed != 0) begin
         for (int i = 0; i < n_typed; i++) begin
            w.code    = typed[i*ByteW +: ByteW];
            w.is_last = (i == n_typed - 1);
            pending_words.push_back(w);
         end
      end else begin
         for (int i = 0; i < n; i++) pending_words.push_back(words[i]);
      end
   endtask

   function automatic logic [SampleW-1:0] random_sample();
      logic [SampleW-1:0] delta;
      int                 width;
      int                 kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
         2: return last_offered;
         default: begin
            // Small steps from the previous sample give short codes of every length.
            width = $urandom_range(1, 31);
            delta = $urandom & (32'hFFFF_FFFF >> (SampleW - width));
            if ($urandom_range(0, 1) == 1) delta = -delta;
            return last_offered + delta;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      code_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word code=%02h last=%0b",
                                      rsp_if.code_byte, rsp_if.last_byte));
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.code_byte !== want.code) begin
               report_mismatch($sformatf("word %0d code_byte %02h, expected %02h",
                                         words_checked, rsp_if.code_byte, want.code));
            end
            if (rsp_if.last_byte !== want.is_last) begin
               report_mismatch($sformatf("word %0d last_byte %0b, expected %0b",
                                         words_checked, rsp_if.last_byte, want.is_last));
            end
         end
         words_checked++;
      end
   end

   // Receiver: mostly ready, with short and long holds, quiet stretches,
   // and one long squeeze that backs the block up into its input.
   initial begin
      int hold_left;
      int calm_left;
      int r;
      hold_left = 0;
      calm_left = 0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            pressure_left   = SqueezeLen;
         end
         if (pressure_left > 0) begin
            rsp_if.ready <= 1'b0;
            pressure_left--;
         end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (calm_left > 0) begin
            rsp_if.ready <= 1'b1;
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_if.ready <= 1'b1;
            end else if (r < 85) begin
               rsp_if.ready <= 1'b0;
               hold_left = $urandom_range(0, 2);
            end else if (r < 95) begin
               rsp_if.ready <= 1'b1;
               calm_left = $urandom_range(20, 60);
            end else begin
               rsp_if.ready <= 1'b0;
               hold_left = $urandom_range(10, 30);
            end
         end
         @(posedge clock);
      end
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int waited;
      clock              = 1'b0;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.sample      <= '0;
      req_if.block_start <= 1'b0;
      last_sample        = '0;
      last_offered       = '0;
      errors             = 0;
      words_checked      = 0;
      samples_sent       = 0;
      starts_sent        = 0;
      send_calm          = 0;
      pressure_left      = 0;
      squeeze_request    = 1'b0;
      foreach (len_count[i]) len_count[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].smp, directed_rows[i].start,
                     directed_rows[i].n_typed, directed_rows[i].bytes);
      end

      for (int k = 0; k < NumRandom; k++) begin
         if (k == SqueezeAt) squeeze_request = 1'b1;
         send_sample(random_sample(), ($urandom_range(0, 7) == 0), 3'd0, '0);
      end
      req_if.valid <= 1'b0;

      waited = 0;
      while (pending_words.size() > 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_words.size() > 0) begin
         report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
      end

      $display("Sent %0d samples (%0d directed, %0d with block start), checked %0d words.",
               samples_sent, NumDirected, starts_sent, words_checked);
      $display("Code lengths 1..5 bytes: %0d %0d %0d %0d %0d samples; %0d mismatches.",
               len_count[1], len_count[2], len_count[3], len_count[4], len_count[5], errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> delta_zigzag_varint_encoder.f
+incdir+design
design/dzve_pkg.sv
design/dzve_if.sv
design/dzve_front.sv
design/dzve_queue.sv
design/dzve_back.sv
design/delta_zigzag_varint_encoder.sv
tb/tb_top.sv
